// ===== rtl/mh64_pkg.sv =====
// Shared constants for the MurmurHash64A byte hasher.
// No dependencies; used by the top level and by the shared multiplier.
`default_nettype none

package mh64_pkg;

  // Mixing multiplier, the seed and the fold shift of the hash.
  localparam logic [63:0] MixM    = 64'hc6a4_a793_5bd1_e995;
  localparam logic [31:0] MixMLo  = MixM[31:0];
  localparam logic [31:0] MixMHi  = MixM[63:32];
  localparam logic [63:0] MixSeed = 64'h0000_0000_e17a_1465;
  localparam int unsigned MixR    = 47;

  // Field widths of one input item.
  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW   = 32;
  localparam int unsigned InDataW = 104;

  localparam logic [CountW-1:0] FullCount = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/mh64_mul.sv =====
// Iterative 64-bit multiply by the hash constant, low 64 bits of the product.
// One 32x32 multiplier is reused for each partial product; depends on mh64_pkg.
`default_nettype none

module mh64_mul
  import mh64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] operand_i,
  output logic        done_o,
  output logic [63:0] product_o
);

  logic [63:0] a_q;
  logic [63:0] acc_q;
  logic [1:0]  step_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // Step 0: lo*lo (full). Step 1: lo*Mhi. Step 2: hi*Mlo. The cross terms
  // only reach the upper half of the result.
  always_comb begin
    if (start_i) begin
      mul_a = operand_i[31:0];
      mul_b = MixMLo;
    end else if (step_q == 2'd1) begin
      mul_a = a_q[31:0];
      mul_b = MixMHi;
    end else begin
      mul_a = a_q[63:32];
      mul_b = MixMLo;
    end
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= 2'd1;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= operand_i;
      acc_q <= mul_p;
    end else if (busy_q) begin
      acc_q[63:32] <= acc_q[63:32] + mul_p[31:0];
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/murmur64a_byte_hash.sv =====
// Top level of the MurmurHash64A byte hasher: stream ports and sequencer.
// Depends on mh64_pkg and on the shared multiplier mh64_mul.
`default_nettype none

// The block hashes a byte message with 64-bit MurmurHash64A. A message comes
// in as little-endian 64-bit items; the item flagged as first also carries the
// total length, which seeds the hash, and the item marked by tlast may hold a
// tail of one to seven bytes or none. One result item, the finished hash and a
// length mismatch flag, leaves on the master side for each message. The block
// takes one input item at a time and drops its ready while working on it. All
// multiplications by the hash constant go through a single 32x32 multiplier,
// one product after another, so the time from one accepted item to the next
// grows with the number of multiplications the item needs: three for a
// full word or a short word before the last, one for a tail, one more for the
// seed on the first item and one more for the finalisation on the last. A last
// item must also hand its result to the output register, and waits longer if
// that register still holds an unread result. A finished result waits in the
// output register, and the next message can be taken in meanwhile.

module murmur64a_byte_hash
  import mh64_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Slave side: one word of a message.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata: data_word [63:0], byte_count [67:64], message_length [99:68],
  // zero padding [103:100]
  input  logic [InDataW-1:0] s_axis_tdata,
  // tuser: first_word
  input  logic               s_axis_tuser,
  // tlast: last_word
  input  logic               s_axis_tlast,
  // Master side: one hash result.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata: hash_value [63:0]
  output logic [63:0]        m_axis_tdata,
  // tuser: length_mismatch
  output logic               m_axis_tuser
);

  typedef enum logic [2:0] {
    StIdle,
    StSeed,
    StDisp,
    StK1,
    StK2,
    StH,
    StFin,
    StOut
  } state_e;

  state_e            state_q;
  logic [WordW-1:0]  word_q;
  logic [CountW-1:0] cnt_q;
  logic              last_q;
  logic [63:0]       h_q;
  logic [63:0]       res_q;
  logic [LenW-1:0]   bytes_q;
  logic [LenW-1:0]   stated_q;
  logic              err_q;
  logic              in_msg_q;
  logic              m_valid_q;
  logic [63:0]       m_data_q;
  logic              m_user_q;

  logic [WordW-1:0]  in_word;
  logic [CountW-1:0] in_cnt_raw;
  logic [LenW-1:0]   in_len;
  logic [CountW-1:0] in_cnt;
  logic [WordW-1:0]  in_masked;
  logic              in_acc;
  logic [LenW-1:0]   base_bytes;
  logic [LenW:0]     sum_bytes;
  logic [LenW-1:0]   new_bytes;
  logic              new_err;

  logic              mul_start;
  logic [63:0]       mul_operand;
  logic              mul_done;
  logic [63:0]       mul_product;
  logic [63:0]       prod_fold;
  logic              do_full;
  logic              do_tail;

  assign in_word    = s_axis_tdata[WordW-1:0];
  assign in_cnt_raw = s_axis_tdata[WordW+CountW-1:WordW];
  assign in_len     = s_axis_tdata[WordW+CountW+LenW-1:WordW+CountW];
  assign in_acc     = s_axis_tvalid && s_axis_tready;

  // A count above eight is taken as eight.
  assign in_cnt = (in_cnt_raw > FullCount) ? FullCount : in_cnt_raw;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_masked[8*i +: 8] = (CountW'(i) < in_cnt) ? in_word[8*i +: 8] : 8'd0;
    end
  end

  // Byte count and error state after this item; a first item starts afresh.
  // The count saturates rather than wrapping, and saturation is an error.
  always_comb begin
    base_bytes = s_axis_tuser ? '0 : bytes_q;
    sum_bytes  = {1'b0, base_bytes} + (LenW + 1)'(in_cnt);
    new_bytes  = sum_bytes[LenW] ? {LenW{1'b1}} : sum_bytes[LenW-1:0];
    new_err    = (s_axis_tuser ? 1'b0 : err_q)
               || (in_cnt_raw > FullCount)
               || ((in_cnt != FullCount) && !s_axis_tlast)
               || sum_bytes[LenW];
  end

  // A full word, or a non-empty short word that is not the last, goes through
  // the whole block mix; a non-empty short last word is folded in as a tail.
  assign do_full = (cnt_q == FullCount) || ((cnt_q != '0) && !last_q);
  assign do_tail = (cnt_q != '0) && (cnt_q != FullCount) && last_q;

  assign prod_fold = mul_product ^ (mul_product >> MixR);

  // Operand selection for the shared multiplier; each product after the first
  // one of a word or tail is started in the cycle the previous one completes.
  always_comb begin
    mul_start   = 1'b0;
    mul_operand = h_q;
    case (state_q)
      StIdle: begin
        if (in_acc && s_axis_tuser) begin
          mul_start   = 1'b1;
          mul_operand = {32'd0, in_len};
        end
      end
      StDisp: begin
        if (do_full) begin
          mul_start   = 1'b1;
          mul_operand = word_q;
        end else if (do_tail) begin
          mul_start   = 1'b1;
          mul_operand = h_q ^ word_q;
        end else if (last_q) begin
          mul_start   = 1'b1;
          mul_operand = h_q ^ (h_q >> MixR);
        end
      end
      StK1: begin
        if (mul_done) begin
          mul_start   = 1'b1;
          mul_operand = prod_fold;
        end
      end
      StK2: begin
        if (mul_done) begin
          mul_start   = 1'b1;
          mul_operand = h_q ^ mul_product;
        end
      end
      StH: begin
        if (mul_done && last_q) begin
          mul_start   = 1'b1;
          mul_operand = prod_fold;
        end
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  mh64_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (mul_operand),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      word_q    <= '0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      h_q       <= '0;
      res_q     <= '0;
      bytes_q   <= '0;
      stated_q  <= '0;
      err_q     <= 1'b0;
      in_msg_q  <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      // In StOut the output register is reloaded below instead.
      if (m_valid_q && m_axis_tready && (state_q != StOut)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          // An item outside an open message, not flagged as first, is dropped.
          if (in_acc && (s_axis_tuser || in_msg_q)) begin
            word_q  <= in_masked;
            cnt_q   <= in_cnt;
            last_q  <= s_axis_tlast;
            bytes_q <= new_bytes;
            err_q   <= new_err;
            if (s_axis_tuser) begin
              stated_q <= in_len;
              in_msg_q <= 1'b1;
              state_q  <= StSeed;
            end else begin
              state_q <= StDisp;
            end
          end
        end
        StSeed: begin
          if (mul_done) begin
            h_q     <= MixSeed ^ mul_product;
            state_q <= StDisp;
          end
        end
        StDisp: begin
          if (do_full) begin
            state_q <= StK1;
          end else if (do_tail) begin
            state_q <= StH;
          end else if (last_q) begin
            state_q <= StFin;
          end else begin
            state_q <= StIdle;
          end
        end
        StK1: begin
          if (mul_done) begin
            state_q <= StK2;
          end
        end
        StK2: begin
          if (mul_done) begin
            state_q <= StH;
          end
        end
        StH: begin
          if (mul_done) begin
            h_q     <= mul_product;
            state_q <= last_q ? StFin : StIdle;
          end
        end
        StFin: begin
          if (mul_done) begin
            res_q   <= prod_fold;
            state_q <= StOut;
          end
        end
        StOut: begin
          // Wait for the output register to be free, then close the message.
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_q;
            m_user_q  <= err_q || (bytes_q != stated_q);
            in_msg_q  <= 1'b0;
            bytes_q   <= '0;
            err_q     <= 1'b0;
            h_q       <= '0;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ===== rtl/mh64_checker.sv =====
// Port-level checks for the MurmurHash64A byte hasher, bound to the top level.
// Depends only on the clock, reset, handshake, first-item and result ports of the top level.
`default_nettype none

module mh64_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A result that is held back keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Accepting a first item keeps ready low while the block seeds the hash.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("first item accepted without seeding time");

  // A new result only appears right after the block was busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while block was idle");

endmodule

bind murmur64a_byte_hash mh64_checker u_mh64_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
